>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ACMR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ACMR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/acmr_pkg.sv
// ----------------------------------------------------------------------------
// acmr_pkg
// Shared constants, codes and helpers of the access-checked message ring.
// ----------------------------------------------------------------------------
`default_nettype none

package acmr_pkg;

	localparam int SLOTS_DEF     = 16;
	localparam int MSG_BYTES_DEF = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN      = 2'd1;

	localparam logic [4:0] SLOTS_IN_USE_RST = 5'd16;
	localparam logic [3:0] MAX_LEN_RST      = 4'd8;
	localparam logic [4:0] COUNT_SAT        = 5'd31;

	typedef enum logic [1:0] {
		MODE_PUSH   = 2'd0,
		MODE_POP    = 2'd1,
		MODE_EXPIRE = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_TOO_LONG = 3'd1,
		STAT_FULL     = 3'd2,
		STAT_EMPTY    = 3'd3,
		STAT_DENIED   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WORK,
		ST_WAIT
	} state_t;

	// keeps the low len bytes of a 64-bit word
	function automatic logic [63:0] byte_mask(input logic [3:0] len);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			m[8*i +: 8] = (4'(i) < len) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage

`default_nettype wire

>>> rtl/acmr_ifs.sv
// ----------------------------------------------------------------------------
// acmr channel interfaces
// Request, response and register-write channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface acmr_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [63:0] payload;
	logic [3:0]  length;
	logic [31:0] user_id;
	logic [31:0] group_id;
	logic [47:0] stamp;
	logic [47:0] expiry_limit;

	modport source (output valid, mode, payload, length, user_id, group_id, stamp,
		expiry_limit, input ready);
	modport sink (input valid, mode, payload, length, user_id, group_id, stamp,
		expiry_limit, output ready);
endinterface

interface acmr_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [3:0]  out_length;
	logic [63:0] out_payload;
	logic [4:0]  aged_count;
	logic [4:0]  message_count;

	modport source (output valid, status, out_length, out_payload, aged_count,
		message_count, input ready);
	modport sink (input valid, status, out_length, out_payload, aged_count,
		message_count, output ready);
endinterface

interface acmr_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/access_checked_message_ring.sv
// ----------------------------------------------------------------------------
// access_checked_message_ring
// Circular queue of owned message slots with push, pop, expire and clear.
// ----------------------------------------------------------------------------
//  channel | dir | transfer carries
//  --------+-----+-------------------------------------------------------------
//  req     | in  | mode, payload, length, user_id, group_id, stamp, expiry_limit
//  rsp     | out | status, out_length, out_payload, aged_count, message_count
//  cfg     | in  | register index, data (always ready)
//
//  Push, pop and clear are accepted in idle, then finish in the work state on the slot read.
//  Expire removes one entry per step; each step passes through a wait state for the
//  registered read data of the slot memory.
//  Reset clears valid marks, indices and count at once; no clearing pass.
//  One result register: the next request is taken while a result waits, and
//  work stalls at completion only while that register is still occupied.
`default_nettype none

module access_checked_message_ring #(
	parameter int SLOTS     = acmr_pkg::SLOTS_DEF,
	parameter int MSG_BYTES = acmr_pkg::MSG_BYTES_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	acmr_req_if.sink  req,
	acmr_rsp_if.source rsp,
	acmr_cfg_if.sink  cfg
);

	import acmr_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int PAY_W = 8 * MSG_BYTES;
	localparam int REC_W = PAY_W + 4 + 32 + 32 + 48;
	localparam int CMP_W = (IDX_W + 1 > 6) ? IDX_W + 1 : 6;
	localparam int SAT_W = (CNT_W > 5) ? CNT_W : 5;

	// registers
	logic [4:0]       slots_in_use_q;
	logic [3:0]       max_len_q;
	logic [SLOTS-1:0] slot_valid_q;
	logic [IDX_W-1:0] wr_idx_q, rd_idx_q;
	logic [CNT_W-1:0] held_cnt_q;
	state_t           state_q, state_d;

	mode_t            mode_q;
	logic [PAY_W-1:0] payload_q;
	logic [3:0]       length_q;
	logic [31:0]      uid_q, gid_q;
	logic [47:0]      stamp_q, limit_q;
	logic [4:0]       before_q;
	logic [4:0]       exp_cnt_q;

	logic             out_valid_q;
	status_t          out_status_q;
	logic [3:0]       out_len_q;
	logic [PAY_W-1:0] out_pay_q;
	logic [4:0]       out_exp_q;
	logic [4:0]       out_cnt_q;

	// slot memory
	logic [REC_W-1:0] wr_rec, rd_rec_s1;
	logic [PAY_W-1:0] rec_pay;
	logic [3:0]       rec_len;
	logic [31:0]      rec_user, rec_group;
	logic [47:0]      rec_stamp;

	// datapath
	logic [CMP_W-1:0] cfg_ext, ring_n;
	logic [IDX_W-1:0] wr_adv, rd_adv;
	logic [3:0]       lim;
	logic [SAT_W-1:0] held_ext;
	logic [4:0]       held_sat;
	logic             vld_rd, vld_wr, access_ok, exp_go, out_free;
	logic             fin, step, push_ok, pop_ok, clr;
	status_t          res_status;
	logic [3:0]       res_len;
	logic [PAY_W-1:0] res_pay;
	logic             in_xfer;

	assign in_xfer = req.valid && req.ready;

	// ring size and index advance
	always_comb begin
		cfg_ext = CMP_W'(slots_in_use_q);
		if (cfg_ext == '0) begin
			ring_n = CMP_W'(1);
		end else if (cfg_ext > CMP_W'(SLOTS)) begin
			ring_n = CMP_W'(SLOTS);
		end else begin
			ring_n = cfg_ext;
		end
	end

	assign wr_adv = (CMP_W'(wr_idx_q) + CMP_W'(1) >= ring_n) ? '0 : wr_idx_q + IDX_W'(1);
	assign rd_adv = (CMP_W'(rd_idx_q) + CMP_W'(1) >= ring_n) ? '0 : rd_idx_q + IDX_W'(1);

	assign lim      = (max_len_q > 4'(MSG_BYTES)) ? 4'(MSG_BYTES) : max_len_q;
	assign held_ext = SAT_W'(held_cnt_q);
	assign held_sat = (held_ext > SAT_W'(COUNT_SAT)) ? COUNT_SAT : held_ext[4:0];

	assign {rec_pay, rec_len, rec_user, rec_group, rec_stamp} = rd_rec_s1;

	assign vld_rd    = slot_valid_q[rd_idx_q];
	assign vld_wr    = slot_valid_q[wr_idx_q];
	assign access_ok = (uid_q == '0) || (uid_q == rec_user) || (gid_q == rec_group);
	assign exp_go    = vld_rd && (rec_stamp < limit_q);
	assign out_free  = !out_valid_q || rsp.ready;

	// result of the item under work
	always_comb begin
		res_status = STAT_OK;
		res_len    = '0;
		res_pay    = '0;
		case (mode_q)
			MODE_PUSH: begin
				if (length_q > lim) begin
					res_status = STAT_TOO_LONG;
				end else if (vld_wr) begin
					res_status = STAT_FULL;
				end else begin
					res_len = length_q;
				end
			end
			MODE_POP: begin
				if (!vld_rd) begin
					res_status = STAT_EMPTY;
				end else if (!access_ok) begin
					res_status = STAT_DENIED;
				end else begin
					res_len = rec_len;
					res_pay = rec_pay & PAY_W'(byte_mask(rec_len));
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		fin     = 1'b0;
		step    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_WORK;
				end
			end
			ST_WORK: begin
				if (mode_q == MODE_EXPIRE && exp_go) begin
					step    = 1'b1;
					state_d = ST_WAIT;
				end else if (out_free) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_WAIT: begin
				// read data follows the new tail index
				state_d = ST_WORK;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	assign push_ok = fin && (mode_q == MODE_PUSH) && (res_status == STAT_OK);
	assign pop_ok  = fin && (mode_q == MODE_POP) && (res_status == STAT_OK);
	assign clr     = fin && (mode_q == MODE_CLEAR);

	assign wr_rec = {payload_q & PAY_W'(byte_mask(length_q)), length_q, uid_q, gid_q, stamp_q};

	acmr_slot_mem #(
		.DEPTH (SLOTS),
		.WIDTH (REC_W)
	) u_slot_mem (
		.clk        (clk),
		.we         (push_ok),
		.wr_addr    (wr_idx_q),
		.wr_data    (wr_rec),
		.rd_addr    (rd_idx_q),
		.rd_data_s1 (rd_rec_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_in_use_q <= SLOTS_IN_USE_RST;
			max_len_q      <= MAX_LEN_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_SLOTS_IN_USE: slots_in_use_q <= cfg.data[4:0];
				REG_MAX_LEN:      max_len_q      <= cfg.data[3:0];
				default: begin
				end
			endcase
		end
	end

	// ring control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			wr_idx_q     <= '0;
			rd_idx_q     <= '0;
			held_cnt_q   <= '0;
		end else if (clr) begin
			slot_valid_q <= '0;
			wr_idx_q     <= '0;
			rd_idx_q     <= '0;
			held_cnt_q   <= '0;
		end else if (push_ok) begin
			slot_valid_q[wr_idx_q] <= 1'b1;
			wr_idx_q               <= wr_adv;
			held_cnt_q             <= held_cnt_q + CNT_W'(1);
		end else if (pop_ok || step) begin
			slot_valid_q[rd_idx_q] <= 1'b0;
			rd_idx_q               <= rd_adv;
			held_cnt_q             <= held_cnt_q - CNT_W'(1);
		end
	end

	// captured request
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_q    <= mode_t'(req.mode);
			payload_q <= req.payload[PAY_W-1:0];
			length_q  <= req.length;
			uid_q     <= req.user_id;
			gid_q     <= req.group_id;
			stamp_q   <= req.stamp;
			limit_q   <= req.expiry_limit;
			before_q  <= held_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_cnt_q <= '0;
		end else if (in_xfer) begin
			exp_cnt_q <= '0;
		end else if (step && exp_cnt_q != COUNT_SAT) begin
			exp_cnt_q <= exp_cnt_q + 5'd1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			out_status_q <= res_status;
			out_len_q    <= res_len;
			out_pay_q    <= res_pay;
			out_exp_q    <= (mode_q == MODE_EXPIRE) ? exp_cnt_q : 5'd0;
			out_cnt_q    <= before_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.out_length    = out_len_q;
	assign rsp.out_payload   = 64'(out_pay_q);
	assign rsp.aged_count    = out_exp_q;
	assign rsp.message_count = out_cnt_q;

	`include "assert_macros.svh"

	`ACMR_ASSERT_IMP(a_cnt, 1'b1, held_cnt_q == CNT_W'($countones(slot_valid_q)), "count off marks")
	`ACMR_ASSERT_NXT(a_clear_empties, clr, {slot_valid_q, rd_idx_q, wr_idx_q} == '0, "ring not empty")
	`ACMR_ASSERT_NXT(a_pop_dec, pop_ok, held_cnt_q == $past(held_cnt_q) - CNT_W'(1), "pop miscount")
	`ACMR_ASSERT_IMP(a_step_in_walk, step, mode_q == MODE_EXPIRE && vld_rd, "stray expire step")

endmodule

`default_nettype wire

>>> rtl/acmr_slot_mem.sv
// ----------------------------------------------------------------------------
// acmr_slot_mem
// Slot record memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module acmr_slot_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 184
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data_s1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= mem[rd_addr];
	end

endmodule

`default_nettype wire
